@@ hdl/tvs_pkg.sv @@
// Shared constants, types and register codes of the trilinear volume sampler.
`timescale 1ns / 1ps
`default_nettype none

package tvs_pkg;

  // Grid, sample and fixed-point geometry.
  localparam int AXIS_BITS   = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = 32;
  localparam int SIZE_W      = 6;
  localparam int SPACE_W     = 24;
  localparam int OUT_W       = 24;
  localparam int CFG_IDX_W   = 3;

  // Quotient bits of the coordinate divider and its pipeline depth.
  localparam int QW       = AXIS_BITS + FRAC_BITS;
  localparam int AXIS_LAT = QW + 2;
  localparam int LIM_W    = AXIS_BITS + SPACE_W;

  // Each of the eight banks holds one parity class of (i, j, k).
  localparam int NBANK   = 8;
  localparam int BANK_AW = 3 * (AXIS_BITS - 1);

  // Register reset values.
  localparam logic [SIZE_W-1:0]  SIZE_RESET    = SIZE_W'(32);
  localparam logic [SPACE_W-1:0] SPACING_RESET = SPACE_W'(65536);

  // Item kinds carried on the input tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_I    = 3'd0,
    REG_SIZE_J    = 3'd1,
    REG_SIZE_K    = 3'd2,
    REG_SPACING_I = 3'd3,
    REG_SPACING_J = 3'd4,
    REG_SPACING_K = 3'd5
  } cfg_reg_t;

  // Item fields that travel beside the coordinate dividers.
  typedef struct packed {
    logic                          valid;
    logic                          op;
    logic [AXIS_BITS-1:0]          vi;
    logic [AXIS_BITS-1:0]          vj;
    logic [AXIS_BITS-1:0]          vk;
    logic signed [SAMPLE_BITS-1:0] value;
  } item_t;

  // Result of one axis: range test, low index and fraction.
  typedef struct packed {
    logic                 outside;
    logic [AXIS_BITS-1:0] lo;
    logic [FRAC_BITS-1:0] frac;
  } axis_res_t;

  // Control that enters the blend pipeline with the eight samples.
  typedef struct packed {
    logic                 valid;
    logic                 outside;
    logic [FRAC_BITS-1:0] fi;
    logic [FRAC_BITS-1:0] fj;
    logic [FRAC_BITS-1:0] fk;
  } blend_ctl_t;

endpackage

`default_nettype wire

@@ hdl/tvs_ram.sv @@
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module tvs_ram #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tvs_axis.sv @@
// One axis: range test and a pipelined restoring divider, one quotient bit a stage.
`timescale 1ns / 1ps
`default_nettype none

module tvs_axis import tvs_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    adv,
  input  wire logic signed [POS_W-1:0] pos,
  input  wire logic [SIZE_W-1:0]       size,
  input  wire logic [SPACE_W-1:0]      spacing,
  output axis_res_t                    res
);

  logic [AXIS_BITS-1:0] szm1;
  logic [SPACE_W-1:0]   sp;

  logic signed [POS_W-1:0] pos_a;
  logic [LIM_W-1:0]        lim_a;

  logic [SPACE_W-1:0] rem [QW+1];
  logic [QW-1:0]      dvd [QW+1];
  logic [QW-1:0]      quo [QW+1];
  logic               oob [QW+1];

  logic [SPACE_W:0]   trial    [QW];
  logic               ge       [QW];
  logic [SPACE_W-1:0] rem_next [QW];

  // Effective size minus one and effective spacing.
  always_comb begin
    if (size == '0) begin
      szm1 = '0;
    end else if (size > SIZE_W'(2**AXIS_BITS)) begin
      szm1 = '1;
    end else begin
      szm1 = AXIS_BITS'(size - SIZE_W'(1));
    end
    sp = (spacing == '0) ? SPACE_W'(1) : spacing;
  end

  // Stage A: upper bound of the axis in Q16 units.
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_a <= pos;
      lim_a <= LIM_W'(szm1) * LIM_W'(sp);
    end
  end

  // Compare and subtract of each divider stage.
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial[s]    = {rem[s], dvd[s][QW-1]};
      ge[s]       = trial[s] >= {1'b0, sp};
      rem_next[s] = ge[s] ? SPACE_W'(trial[s] - {1'b0, sp}) : trial[s][SPACE_W-1:0];
    end
  end

  // Stage B sets up the range test and the divider; the top dividend bits form the
  // first remainder. The divider stages follow, one quotient bit a cycle while adv is high.
  always_ff @(posedge clk) begin
    if (adv) begin
      oob[0] <= pos_a[POS_W-1] || (pos_a[POS_W-2:0] > (POS_W-1)'(lim_a));
      rem[0] <= pos_a[AXIS_BITS +: SPACE_W];
      dvd[0] <= {pos_a[AXIS_BITS-1:0], {FRAC_BITS{1'b0}}};
      quo[0] <= '0;
      for (int s = 0; s < QW; s++) begin
        rem[s+1] <= rem_next[s];
        dvd[s+1] <= {dvd[s][QW-2:0], 1'b0};
        quo[s+1] <= {quo[s][QW-2:0], ge[s]};
        oob[s+1] <= oob[s];
      end
    end
  end

  assign res.outside = oob[QW];
  assign res.lo      = quo[QW][QW-1:FRAC_BITS];
  assign res.frac    = quo[QW][FRAC_BITS-1:0];

endmodule

`default_nettype wire

@@ hdl/tvs_blend.sv @@
// Blend pipeline: k, j and i linear steps, saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none

module tvs_blend import tvs_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          out_adv,
  input  wire blend_ctl_t                    ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] smp [NBANK],
  output logic                               last_busy,
  output logic                               res_valid,
  output logic signed [OUT_W-1:0]            res_sample,
  output logic                               res_outside
);

  localparam int W1   = FRAC_BITS + 1;
  localparam int PK_W = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int SK_W = PK_W + 1;
  localparam int C_W  = SK_W - (FRAC_BITS - 8);
  localparam int PJ_W = C_W + FRAC_BITS + 1;
  localparam int SJ_W = PJ_W + 1;
  localparam int D_W  = SJ_W - FRAC_BITS;
  localparam int PI_W = D_W + FRAC_BITS + 1;
  localparam int SI_W = PI_W + 1;
  localparam int R_W  = SI_W - FRAC_BITS;

  logic [W1-1:0] w0k, w1k, w0j, w1j, w0i, w1i;

  logic                 v1, v2, v3, v4, v5;
  logic                 o1, o2, o3, o4, o5;
  logic [FRAC_BITS-1:0] fj1, fj2, fi1, fi2, fi3, fi4;

  logic signed [PK_W-1:0] pk [4][2];
  logic signed [C_W-1:0]  cv [4];
  logic signed [PJ_W-1:0] pj [2][2];
  logic signed [D_W-1:0]  dv [2];
  logic signed [PI_W-1:0] pi [2];

  logic signed [SK_W-1:0] sk [4];
  logic signed [SJ_W-1:0] sj [2];
  logic signed [SI_W-1:0] si;
  logic signed [R_W-1:0]  rv;
  logic signed [OUT_W-1:0] sat;

  // Weights of the low and high neighbor on each axis.
  always_comb begin
    w1k = {1'b0, ctl.fk};
    w0k = {1'b1, {FRAC_BITS{1'b0}}} - w1k;
    w1j = {1'b0, fj2};
    w0j = {1'b1, {FRAC_BITS{1'b0}}} - w1j;
    w1i = {1'b0, fi4};
    w0i = {1'b1, {FRAC_BITS{1'b0}}} - w1i;
  end

  // Sums and floor shifts of each step.
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      sk[n] = SK_W'(pk[n][0]) + SK_W'(pk[n][1]);
    end
    for (int m = 0; m < 2; m++) begin
      sj[m] = SJ_W'(pj[m][0]) + SJ_W'(pj[m][1]);
    end
    si = SI_W'(pi[0]) + SI_W'(pi[1]);
    rv = si[SI_W-1:FRAC_BITS];
    if (rv[R_W-1:OUT_W-1] != '0 && rv[R_W-1:OUT_W-1] != '1) begin
      sat = rv[R_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      sat = rv[OUT_W-1:0];
    end
  end

  // Control beside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Data stages: products along k, then j, then i, each summed one stage later.
  always_ff @(posedge clk) begin
    if (adv) begin
      o1  <= ctl.outside;
      o2  <= o1;
      o3  <= o2;
      o4  <= o3;
      o5  <= o4;
      fj1 <= ctl.fj;
      fj2 <= fj1;
      fi1 <= ctl.fi;
      fi2 <= fi1;
      fi3 <= fi2;
      fi4 <= fi3;
      for (int n = 0; n < 4; n++) begin
        pk[n][0] <= PK_W'(smp[2*n])   * PK_W'($signed({1'b0, w0k}));
        pk[n][1] <= PK_W'(smp[2*n+1]) * PK_W'($signed({1'b0, w1k}));
        cv[n]    <= sk[n][SK_W-1:FRAC_BITS-8];
      end
      for (int m = 0; m < 2; m++) begin
        pj[m][0] <= PJ_W'(cv[2*m])   * PJ_W'($signed({1'b0, w0j}));
        pj[m][1] <= PJ_W'(cv[2*m+1]) * PJ_W'($signed({1'b0, w1j}));
        dv[m]    <= sj[m][SJ_W-1:FRAC_BITS];
      end
      pi[0] <= PI_W'(dv[0]) * PI_W'($signed({1'b0, w0i}));
      pi[1] <= PI_W'(dv[1]) * PI_W'($signed({1'b0, w1i}));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_adv) begin
      res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      res_sample  <= o5 ? '0 : sat;
      res_outside <= o5;
    end
  end

  assign last_busy = v5;

endmodule

`default_nettype wire

@@ hdl/trilinear_volume_sampler.sv @@
// Top level of the trilinear volume sampler: registers, dividers, banked volume, blend.
//
//  Channel  | Direction | Beat
//  s_*      | in        | tdata: pos_i, pos_j, pos_k, voxel_i, voxel_j, voxel_k, voxel_value
//           |           | tuser: operation (0 write voxel, 1 query)
//  m_*      | out       | tdata: sample; tuser: outside; one beat per query
//  cfg_*    | in        | cfg_index selects the register, cfg_data carries its value
//
// One item is taken every cycle while s_tready is high. A query result passes through
// the 21-stage coordinate divider, then the bank read and the blend.
// The volume is split into eight banks by index parity so all eight corners read at once.
// Reset is synchronous; it clears the control state, loads the reset values of the registers,
// not the volume. A stalled output holds the pipeline only when its last stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module trilinear_volume_sampler import tvs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // pos_i[31:0], pos_j[63:32], pos_k[95:64], voxel_i[100:96], voxel_j[105:101],
  // voxel_k[110:106], voxel_value[126:111], zero pad[127]
  input  wire logic [127:0]         s_tdata,
  // operation[0]
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // sample[23:0]
  output logic [OUT_W-1:0]          m_tdata,
  // outside[0]
  output logic                      m_tuser,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SPACE_W-1:0]   cfg_data
);

  logic adv, out_adv, last_busy;

  logic [SIZE_W-1:0]  size_i, size_j, size_k;
  logic [SPACE_W-1:0] spacing_i, spacing_j, spacing_k;

  item_t                   s0;
  logic signed [POS_W-1:0] pos_i, pos_j, pos_k;
  item_t                   sb [AXIS_LAT];
  item_t                   mi;
  axis_res_t               ri, rj, rk;

  logic [AXIS_BITS-1:0]   idx_i [NBANK];
  logic [AXIS_BITS-1:0]   idx_j [NBANK];
  logic [AXIS_BITS-1:0]   idx_k [NBANK];
  logic [BANK_AW-1:0]     raddr [NBANK];
  logic [BANK_AW-1:0]     waddr;
  logic [2:0]             wbank;
  logic [NBANK-1:0]       we;
  logic                   re;
  logic [SAMPLE_BITS-1:0] rdata [NBANK];

  blend_ctl_t                    rctl;
  logic [2:0]                    par;
  logic signed [SAMPLE_BITS-1:0] smp [NBANK];

  // Pipeline advance: the output moves when free or taken; the rest also moves into a hole.
  assign out_adv  = !m_tvalid || m_tready;
  assign adv      = out_adv || !last_busy;
  assign s_tready = adv;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_i    <= SIZE_RESET;
      size_j    <= SIZE_RESET;
      size_k    <= SIZE_RESET;
      spacing_i <= SPACING_RESET;
      spacing_j <= SPACING_RESET;
      spacing_k <= SPACING_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_I:    size_i    <= cfg_data[SIZE_W-1:0];
        REG_SIZE_J:    size_j    <= cfg_data[SIZE_W-1:0];
        REG_SIZE_K:    size_k    <= cfg_data[SIZE_W-1:0];
        REG_SPACING_I: spacing_i <= cfg_data;
        REG_SPACING_J: spacing_j <= cfg_data;
        REG_SPACING_K: spacing_k <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (adv) begin
      s0.valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_i    <= s_tdata[31:0];
      pos_j    <= s_tdata[63:32];
      pos_k    <= s_tdata[95:64];
      s0.op    <= s_tuser;
      s0.vi    <= s_tdata[96 +: AXIS_BITS];
      s0.vj    <= s_tdata[101 +: AXIS_BITS];
      s0.vk    <= s_tdata[106 +: AXIS_BITS];
      s0.value <= SAMPLE_BITS'(s_tdata[126:111]);
    end
  end

  // Coordinate dividers, one per axis.
  tvs_axis u_axis_i (
    .clk(clk), .adv(adv), .pos(pos_i), .size(size_i), .spacing(spacing_i), .res(ri)
  );
  tvs_axis u_axis_j (
    .clk(clk), .adv(adv), .pos(pos_j), .size(size_j), .spacing(spacing_j), .res(rj)
  );
  tvs_axis u_axis_k (
    .clk(clk), .adv(adv), .pos(pos_k), .size(size_k), .spacing(spacing_k), .res(rk)
  );

  // Item fields delayed to line up with the divider results.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < AXIS_LAT; s++) begin
        sb[s].valid <= 1'b0;
      end
    end else if (adv) begin
      sb[0] <= s0;
      for (int s = 1; s < AXIS_LAT; s++) begin
        sb[s] <= sb[s-1];
      end
    end
  end

  assign mi = sb[AXIS_LAT-1];

  // Bank addresses: the bank whose parity matches the low index reads it, the other
  // reads the next index.
  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      idx_i[b] = (ri.lo[0] == b[2]) ? ri.lo : ri.lo + AXIS_BITS'(1);
      idx_j[b] = (rj.lo[0] == b[1]) ? rj.lo : rj.lo + AXIS_BITS'(1);
      idx_k[b] = (rk.lo[0] == b[0]) ? rk.lo : rk.lo + AXIS_BITS'(1);
      raddr[b] = {idx_i[b][AXIS_BITS-1:1], idx_j[b][AXIS_BITS-1:1], idx_k[b][AXIS_BITS-1:1]};
    end
    wbank = {mi.vi[0], mi.vj[0], mi.vk[0]};
    waddr = {mi.vi[AXIS_BITS-1:1], mi.vj[AXIS_BITS-1:1], mi.vk[AXIS_BITS-1:1]};
    for (int b = 0; b < NBANK; b++) begin
      we[b] = adv && mi.valid && (mi.op == OP_WRITE) && (wbank == 3'(b));
    end
    re = adv;
  end

  // Volume banks. Reads and writes happen at the same stage, so they keep item order.
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    tvs_ram #(.AW(BANK_AW), .DW(SAMPLE_BITS)) u_ram (
      .clk   (clk),
      .we    (we[b]),
      .waddr (waddr),
      .wdata (mi.value),
      .re    (re),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  // Read stage control, aligned with the bank data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rctl.valid <= 1'b0;
    end else if (adv) begin
      rctl.valid <= mi.valid && (mi.op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rctl.outside <= ri.outside || rj.outside || rk.outside;
      rctl.fi      <= ri.frac;
      rctl.fj      <= rj.frac;
      rctl.fk      <= rk.frac;
      par          <= {ri.lo[0], rj.lo[0], rk.lo[0]};
    end
  end

  // Map banks to corners. A high neighbor with zero fraction carries no weight and is zeroed.
  always_comb begin
    for (int c = 0; c < NBANK; c++) begin
      if ((c[2] && rctl.fi == '0) || (c[1] && rctl.fj == '0) || (c[0] && rctl.fk == '0)) begin
        smp[c] = '0;
      end else begin
        smp[c] = rdata[3'(c) ^ par];
      end
    end
  end

  tvs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .out_adv     (out_adv),
    .ctl         (rctl),
    .smp         (smp),
    .last_busy   (last_busy),
    .res_valid   (m_tvalid),
    .res_sample  (m_tdata),
    .res_outside (m_tuser)
  );

endmodule

`default_nettype wire

@@ verif/trilinear_volume_sampler_test.sv @@
// Self-checking testbench of the trilinear volume sampler: volume fill, directed and random items.
`timescale 1ns / 1ps

module trilinear_volume_sampler_test;
  import tvs_pkg::*;

  localparam int DRAIN_CYCLES = 45;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 110;
  // Points per axis of the filled corner of the volume; every grid size stays within it.
  localparam int FILL         = 6;

  typedef struct {
    logic                     op;
    logic signed [POS_W-1:0]  pi, pj, pk;
    logic [AXIS_BITS-1:0]     vi, vj, vk;
    logic signed [15:0]       value;
    bit                       typed;
    logic signed [OUT_W-1:0]  want_sample;
    logic                     want_outside;
  } beat_t;

  typedef struct {
    logic signed [OUT_W-1:0] sample;
    logic                    outside;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SPACE_W-1:0] cfg_data = '0;

  // Shadow copy of the volume and of the registers.
  logic signed [15:0] shadow_vol [0:32767];
  logic [SIZE_W-1:0]  grid_size [0:2];
  logic [SPACE_W-1:0] grid_pitch [0:2];

  sample_t pending_samples[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  trilinear_volume_sampler DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output back-pressure, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Compare each output beat with the oldest pending sample.
  always @(posedge clk) begin
    sample_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected beat, sample", $signed(m_tdata), 0);
      end else begin
        want = pending_samples.pop_front();
        if ($signed(m_tdata) !== want.sample)
          report_mismatch("sample", $signed(m_tdata), want.sample);
        if (m_tuser !== want.outside)
          report_mismatch("outside", m_tuser, want.outside);
      end
    end
  end

  // Low index, high index and fraction along one axis; 0 when outside.
  function automatic bit axis_cell(input logic signed [POS_W-1:0] p, input int ax,
                                   output int lo, output int hi, output longint fr);
    longint sz, sp, u;
    sz = (grid_size[ax] == 0) ? 1 : (grid_size[ax] > 32) ? 32 : grid_size[ax];
    sp = (grid_pitch[ax] == 0) ? 1 : grid_pitch[ax];
    if (p < 0 || longint'(p) > (sz - 1) * sp) return 1'b0;
    u = (longint'(p) <<< FRAC_BITS) / sp;
    lo = int'(u >>> FRAC_BITS);
    if (lo > sz - 1) lo = int'(sz - 1);
    fr = u & 64'hFFFF;
    hi = (lo < sz - 1) ? lo + 1 : lo;
    return 1'b1;
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint f,
                                  input int sh);
    return (a * (65536 - f) + b * f) >>> sh;
  endfunction

  function automatic longint voxel(input int i, input int j, input int k);
    return longint'(shadow_vol[(i << 10) | (j << 5) | k]);
  endfunction

  function automatic sample_t interpolate(input beat_t b);
    sample_t r;
    int i0, i1, j0, j1, k0, k1;
    longint fi, fj, fk, c00, c01, c10, c11, d0, d1, v;
    r.sample = '0;
    r.outside = 1'b1;
    if (!axis_cell(b.pi, 0, i0, i1, fi) || !axis_cell(b.pj, 1, j0, j1, fj) ||
        !axis_cell(b.pk, 2, k0, k1, fk))
      return r;
    // Blend along k, then j, then i, keeping 8 fractional bits.
    c00 = lerp(voxel(i0, j0, k0), voxel(i0, j0, k1), fk, 8);
    c01 = lerp(voxel(i0, j1, k0), voxel(i0, j1, k1), fk, 8);
    c10 = lerp(voxel(i1, j0, k0), voxel(i1, j0, k1), fk, 8);
    c11 = lerp(voxel(i1, j1, k0), voxel(i1, j1, k1), fk, 8);
    d0 = lerp(c00, c01, fj, 16);
    d1 = lerp(c10, c11, fj, 16);
    v = lerp(d0, d1, fi, 16);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    r.sample = v[OUT_W-1:0];
    r.outside = 1'b0;
    return r;
  endfunction

  // Offer one beat after a random gap; record its effect once accepted.
  task automatic send_beat(input beat_t b);
    sample_t want;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= b.op;
    s_tdata <= {1'b0, b.value, b.vk, b.vj, b.vi, b.pk, b.pj, b.pi};
    do @(posedge clk); while (!s_tready);
    if (b.op == OP_WRITE) begin
      shadow_vol[{b.vi, b.vj, b.vk}] = b.value;
    end else if (b.typed) begin
      want.sample = b.want_sample;
      want.outside = b.want_outside;
      pending_samples.push_back(want);
    end else begin
      pending_samples.push_back(interpolate(b));
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[SPACE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= REG_SIZE_K) grid_size[idx] = val[SIZE_W-1:0];
    else grid_pitch[idx - REG_SPACING_I] = val[SPACE_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_grid(input int si, input int sj, input int sk,
                          input int pi, input int pj, input int pk);
    wait_idle();
    write_reg(REG_SIZE_I, si);
    write_reg(REG_SIZE_J, sj);
    write_reg(REG_SIZE_K, sk);
    write_reg(REG_SPACING_I, pi);
    write_reg(REG_SPACING_J, pj);
    write_reg(REG_SPACING_K, pk);
  endtask

  function automatic beat_t query(input int pi, input int pj, input int pk);
    beat_t b;
    b = '{default: '0};
    b.op = OP_QUERY;
    b.pi = pi;
    b.pj = pj;
    b.pk = pk;
    return b;
  endfunction

  function automatic beat_t query_out(input int pi, input int pj, input int pk);
    beat_t b;
    b = query(pi, pj, pk);
    b.typed = 1'b1;
    b.want_outside = 1'b1;
    return b;
  endfunction

  function automatic beat_t voxel_write(input int i, input int j, input int k, input int v);
    beat_t b;
    b = '{default: '0};
    b.op = OP_WRITE;
    b.vi = i[AXIS_BITS-1:0];
    b.vj = j[AXIS_BITS-1:0];
    b.vk = k[AXIS_BITS-1:0];
    b.value = v[15:0];
    return b;
  endfunction

  // Random coordinate: mostly inside, some on the last plane, some outside.
  function automatic int rand_pos(input int ax);
    int sz, lim, sel;
    sz = (grid_size[ax] == 0) ? 1 : (grid_size[ax] > 32) ? 32 : grid_size[ax];
    lim = (sz - 1) * grid_pitch[ax];
    sel = $urandom_range(99);
    if (sel < 75) return $urandom_range(lim, 0);
    if (sel < 85) return lim;
    if (sel < 90) return -$urandom_range(1000, 1);
    if (sel < 95) return lim + $urandom_range(1000, 1);
    return $urandom;
  endfunction

  function automatic beat_t rand_beat();
    if ($urandom_range(99) < 15)
      return voxel_write($urandom_range(FILL - 1), $urandom_range(FILL - 1),
                         $urandom_range(FILL - 1), $urandom_range(65535));
    return query(rand_pos(0), rand_pos(1), rand_pos(2));
  endfunction

  beat_t directed [$];

  initial begin
    grid_size = '{32, 32, 32};
    grid_pitch = '{65536, 65536, 65536};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the corner of the volume that every grid below stays within.
    for (int i = 0; i < FILL; i++)
      for (int j = 0; j < FILL; j++)
        for (int k = 0; k < FILL; k++)
          send_beat(voxel_write(i, j, k, $urandom_range(65535)));

    // Directed checks on a grid that covers the filled corner.
    set_grid(FILL, FILL, FILL, 65536, 65536, 65536);
    directed.push_back(query(0, 0, 0));
    directed.push_back(query((FILL - 1) << 16, (FILL - 1) << 16, (FILL - 1) << 16));
    directed.push_back(query((FILL - 1) << 16, 32'h18000, 32'h8000));
    directed.push_back(query(32'h8000, (FILL - 1) << 16, 32'h4000));
    directed.push_back(query_out(-1, 0, 0));
    directed.push_back(query_out(0, ((FILL - 1) << 16) + 1, 0));
    directed.push_back(query_out(0, 0, 32'h80000000));
    directed.push_back(query_out(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(voxel_write(FILL - 1, FILL - 1, FILL - 1, -32768));
    directed.push_back(voxel_write(0, 0, 0, 32767));
    directed.push_back(voxel_write(FILL - 2, FILL - 1, FILL - 1, -32768));
    directed.push_back(query(0, 0, 0));
    directed.push_back(query((FILL - 1) << 16, (FILL - 1) << 16, (FILL - 1) << 16));
    directed.push_back(query(((FILL - 2) << 16) + 32'h8000, (FILL - 1) << 16,
                             (FILL - 1) << 16));
    directed.push_back(query(32'h0FFFF, 32'h0FFFF, 32'h0FFFF));
    foreach (directed[n]) send_beat(directed[n]);

    // Several grid settings, each under one of four idling mixes.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_grid(FILL, FILL, FILL, 65536, 65536, 65536);
        1: set_grid(0, 1, 1, 16777215, 16777215, 16777215);
        3: set_grid(FILL, FILL, FILL, 1, 1, 1);
        5: set_grid($urandom_range(FILL, 2), $urandom_range(FILL, 2),
                    $urandom_range(FILL, 2), 65536, 65536, 65536);
        default: set_grid($urandom_range(FILL, 1), $urandom_range(FILL, 1),
                          $urandom_range(FILL, 1), $urandom_range(16777215, 1),
                          $urandom_range(300000, 1), $urandom_range(16777215, 1));
      endcase
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 54; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 54; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        // Long output hold-off while input keeps flowing.
        if (phase == 0 && n == 20) hold_cycles = 300;
        // Sender pause until every pending sample has come back.
        if (phase == 2 && n == 75) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_samples.size() != 0) @(posedge clk);
        end
        send_beat(rand_beat());
      end
    end

    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
